// File: rtl/sre_pkg.sv
package sre_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int PC_W      = 16;

    localparam logic [31:0] BASE_RESET = 32'd256;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BREAK   = 3'd1,
        ST_HALTED  = 3'd2,
        ST_RANGE   = 3'd3,
        ST_ILLEGAL = 3'd4
    } status_t;

    localparam logic [1:0] CAT_JUMP   = 2'd0;
    localparam logic [1:0] CAT_REG    = 2'd1;
    localparam logic [1:0] CAT_IMM    = 2'd2;
    localparam logic [1:0] CAT_BRANCH = 2'd3;

    localparam logic [4:0] OP_JAL   = 5'd0;
    localparam logic [4:0] OP_BREAK = 5'd31;

    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_AND = 5'd2;
    localparam logic [4:0] OP_OR  = 5'd3;

    localparam logic [4:0] OP_ADDI = 5'd0;
    localparam logic [4:0] OP_ANDI = 5'd1;
    localparam logic [4:0] OP_ORI  = 5'd2;
    localparam logic [4:0] OP_SLL  = 5'd3;
    localparam logic [4:0] OP_SRA  = 5'd4;
    localparam logic [4:0] OP_LW   = 5'd5;

    localparam logic [4:0] OP_BEQ = 5'd0;
    localparam logic [4:0] OP_BNE = 5'd1;
    localparam logic [4:0] OP_BLT = 5'd2;
    localparam logic [4:0] OP_SW  = 5'd3;

endpackage

// File: rtl/small_risc_instruction_executor.sv
// Executes one instruction (kind 0) or preloads one data memory word (kind 1)
// per transaction, one transaction per cycle sustained while the output is not
// stalled. A transaction passes through the execute stage, where operands are
// read from registered register file ports and pc, halt and data memory are
// updated, and then sits in the output stage, which presents its result.
// lw data comes from the data memory's registered read port in the output
// stage and is forwarded to the following instruction, so lw adds no bubble.
// Register file reset is immediate (per-entry valid bits); no clearing pass.
// base_address may only be written while no transaction is in flight.
module small_risc_instruction_executor
    import sre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] base_address,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] instr_word,
    input  logic [9:0]  load_index,
    input  logic signed [31:0] load_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] next_address,
    output logic        reg_written,
    output logic [4:0]  reg_number,
    output logic signed [31:0] reg_value,
    output logic        mem_written,
    output logic [9:0]  mem_index,
    output logic signed [31:0] mem_value,
    output logic        branch_taken
);

    logic [31:0]     base_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            halted_reg;
    logic            halted_next;

    // execute stage
    logic            e_valid_reg;
    logic            e_kind_reg;
    logic [31:0]     e_instr_reg;
    logic [9:0]      e_lidx_reg;
    logic [31:0]     e_lval_reg;
    logic [31:0]     op_a_reg;
    logic [31:0]     op_b_reg;

    // output stage
    logic            w_valid_reg;
    status_t         w_status_reg;
    logic [PC_W-1:0] w_pc_reg;
    logic            w_wr_reg;
    logic [4:0]      w_rd_reg;
    logic [31:0]     w_val_reg;
    logic            w_lw_reg;
    logic            w_mw_reg;
    logic [9:0]      w_midx_reg;
    logic [31:0]     w_mval_reg;
    logic            w_taken_reg;

    logic            advance;
    logic            accept;
    logic            e_fire;

    // register file
    logic [31:0]       rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [31:0]       rf_wdata;
    logic [REG_AW-1:0] ra_addr;
    logic [REG_AW-1:0] rb_addr;

    // data memory
    logic [31:0]       dmem [MEM_WORDS];
    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_waddr;
    logic [MEM_AW-1:0] mem_raddr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata_reg;

    // decode
    logic [1:0]  cat;
    logic [4:0]  opc;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_j;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] cur_addr;
    logic [31:0] lw_off;
    logic [31:0] sw_off;
    logic        lw_ok;
    logic        sw_ok;
    logic        pre_ok;

    status_t     x_status;
    logic        x_wr;
    logic [31:0] x_val;
    logic        x_lw;
    logic        x_mw;
    logic [9:0]  x_midx;
    logic [31:0] x_mval;
    logic        x_taken;
    logic        x_mem_we;
    logic        x_mem_re;

    assign cfg_ready = 1'b1;

    assign advance  = !w_valid_reg || !out_stall;
    assign in_stall = e_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign e_fire   = e_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= base_address;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            e_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            e_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_kind_reg  <= kind;
            e_instr_reg <= instr_word;
            e_lidx_reg  <= load_index;
            e_lval_reg  <= load_value;
        end
    end

    // register file: write from the output stage, write-first read ports
    assign rf_we    = w_valid_reg && w_wr_reg;
    assign rf_waddr = w_rd_reg;
    assign rf_wdata = w_lw_reg ? mem_rdata_reg : w_val_reg;

    assign ra_addr = accept ? instr_word[19:15] : e_instr_reg[19:15];
    assign rb_addr = accept ? instr_word[24:20] : e_instr_reg[24:20];

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[rf_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we && rf_waddr == ra_addr)
        begin
            op_a_reg <= rf_wdata;
        end
        else if (rf_valid_reg[ra_addr])
        begin
            op_a_reg <= rf_mem[ra_addr];
        end
        else
        begin
            op_a_reg <= '0;
        end

        if (rf_we && rf_waddr == rb_addr)
        begin
            op_b_reg <= rf_wdata;
        end
        else if (rf_valid_reg[rb_addr])
        begin
            op_b_reg <= rf_mem[rb_addr];
        end
        else
        begin
            op_b_reg <= '0;
        end
    end

    // execute
    assign cat = e_instr_reg[1:0];
    assign opc = e_instr_reg[6:2];
    assign rd  = e_instr_reg[11:7];
    assign rs1 = e_instr_reg[19:15];
    assign rs2 = e_instr_reg[24:20];

    assign imm_j = {{12{e_instr_reg[31]}}, e_instr_reg[31:12]};
    assign imm_i = {{20{e_instr_reg[31]}}, e_instr_reg[31:20]};
    assign imm_s = {{20{e_instr_reg[31]}}, e_instr_reg[31:25], e_instr_reg[11:7]};

    // forward the result still in the output stage
    assign a = (rf_we && rf_waddr == rs1) ? rf_wdata : op_a_reg;
    assign b = (rf_we && rf_waddr == rs2) ? rf_wdata : op_b_reg;

    assign cur_addr = base_reg + {14'd0, pc_reg, 2'b00};
    assign lw_off   = a + imm_i - base_reg;
    assign sw_off   = b + imm_s - base_reg;
    assign lw_ok    = lw_off[31:2] < 30'(MEM_WORDS);
    assign sw_ok    = sw_off[31:2] < 30'(MEM_WORDS);
    assign pre_ok   = 32'(e_lidx_reg) < 32'(MEM_WORDS);

    always_comb
    begin
        x_status    = ST_OK;
        pc_next     = pc_reg + PC_W'(1);
        halted_next = halted_reg;
        x_wr        = 1'b0;
        x_val       = '0;
        x_lw        = 1'b0;
        x_mw        = 1'b0;
        x_midx      = '0;
        x_mval      = '0;
        x_taken     = 1'b0;
        x_mem_we    = 1'b0;
        x_mem_re    = 1'b0;
        mem_waddr   = MEM_AW'(sw_off[31:2]);
        mem_wdata   = a;
        mem_raddr   = MEM_AW'(lw_off[31:2]);

        priority if (e_kind_reg)
        begin
            pc_next   = pc_reg;
            mem_waddr = MEM_AW'(e_lidx_reg);
            mem_wdata = e_lval_reg;
            if (pre_ok)
            begin
                x_mem_we = 1'b1;
            end
            else
            begin
                x_status = ST_RANGE;
            end
        end
        else if (halted_reg)
        begin
            x_status = ST_HALTED;
            pc_next  = pc_reg;
        end
        else
        begin
            unique case (cat)
                CAT_JUMP:
                begin
                    if (opc == OP_JAL)
                    begin
                        x_wr    = 1'b1;
                        x_val   = cur_addr + 32'd4;
                        x_taken = 1'b1;
                        pc_next = pc_reg + imm_j[PC_W:1];
                    end
                    else if (opc == OP_BREAK)
                    begin
                        halted_next = 1'b1;
                        x_status    = ST_BREAK;
                        pc_next     = pc_reg;
                    end
                    else
                    begin
                        x_status = ST_ILLEGAL;
                    end
                end
                CAT_REG:
                begin
                    x_wr = 1'b1;
                    unique case (opc)
                        OP_ADD:  x_val = a + b;
                        OP_SUB:  x_val = a - b;
                        OP_AND:  x_val = a & b;
                        OP_OR:   x_val = a | b;
                        default:
                        begin
                            x_wr     = 1'b0;
                            x_status = ST_ILLEGAL;
                        end
                    endcase
                end
                CAT_IMM:
                begin
                    x_wr = 1'b1;
                    unique case (opc)
                        OP_ADDI: x_val = a + imm_i;
                        OP_ANDI: x_val = a & imm_i;
                        OP_ORI:  x_val = a | imm_i;
                        OP_SLL:  x_val = a << imm_i[4:0];
                        OP_SRA:  x_val = $signed(a) >>> imm_i[4:0];
                        OP_LW:
                        begin
                            if (lw_ok)
                            begin
                                x_lw     = 1'b1;
                                x_mem_re = 1'b1;
                            end
                            else
                            begin
                                x_wr     = 1'b0;
                                x_status = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            x_wr     = 1'b0;
                            x_status = ST_ILLEGAL;
                        end
                    endcase
                end
                CAT_BRANCH:
                begin
                    unique case (opc)
                        OP_BEQ:  x_taken = (a == b);
                        OP_BNE:  x_taken = (a != b);
                        OP_BLT:  x_taken = ($signed(a) < $signed(b));
                        OP_SW:
                        begin
                            if (sw_ok)
                            begin
                                x_mem_we = 1'b1;
                                x_mw     = 1'b1;
                                x_midx   = sw_off[11:2];
                                x_mval   = a;
                            end
                            else
                            begin
                                x_status = ST_RANGE;
                            end
                        end
                        default: x_status = ST_ILLEGAL;
                    endcase
                    if (x_taken)
                    begin
                        pc_next = pc_reg + imm_s[PC_W:1];
                    end
                end
                default: x_status = ST_ILLEGAL;
            endcase
        end
    end

    assign mem_we = e_fire && x_mem_we;
    assign mem_re = e_fire && x_mem_re;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dmem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= dmem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else if (e_fire)
        begin
            pc_reg     <= pc_next;
            halted_reg <= halted_next;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            w_status_reg <= x_status;
            w_pc_reg     <= pc_next;
            w_wr_reg     <= x_wr;
            w_rd_reg     <= x_wr ? rd : 5'd0;
            w_val_reg    <= x_val;
            w_lw_reg     <= x_lw;
            w_mw_reg     <= x_mw;
            w_midx_reg   <= x_midx;
            w_mval_reg   <= x_mval;
            w_taken_reg  <= x_taken;
        end
    end

    assign out_valid    = w_valid_reg;
    assign status       = w_status_reg;
    assign next_address = base_reg + {14'd0, w_pc_reg, 2'b00};
    assign reg_written  = w_wr_reg;
    assign reg_number   = w_rd_reg;
    assign reg_value    = rf_wdata;
    assign mem_written  = w_mw_reg;
    assign mem_index    = w_midx_reg;
    assign mem_value    = w_mval_reg;
    assign branch_taken = w_taken_reg;

    a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("data memory read and write in one cycle");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared");

    a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> $stable(pc_reg))
        else $error("pc moved while halted");

    a_lw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid_reg && w_lw_reg) |-> (w_wr_reg && w_status_reg == ST_OK))
        else $error("lw in output stage without register write");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid_reg && w_taken_reg) |-> (w_status_reg == ST_OK))
        else $error("control transfer with error status");

endmodule
